// ----- rtl/io_supply_drive_supervisor_core_macros.svh -----
// assertion macros for the i/o supply drive supervisor
// used by io_supply_drive_supervisor_core, expects i_clk and i_rst_n in scope
`ifndef IO_SUPPLY_DRIVE_SUPERVISOR_CORE_MACROS_SVH
`define IO_SUPPLY_DRIVE_SUPERVISOR_CORE_MACROS_SVH

`ifndef SYNTH
`define IOSDS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define IOSDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IOSDS_ASSERT(lbl, cond, msg)
`define IOSDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/iosds_pkg.sv -----
// types and constants of the i/o supply drive supervisor
// no dependencies; imported by io_supply_drive_supervisor_core
`timescale 1ns / 1ps
`default_nettype none

package iosds_pkg;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_TARGET = 2'd1,
        CMD_USB    = 2'd2,
        CMD_DRIVE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_DISABLED = 3'b001,
        ST_ENABLED  = 3'b010,
        ST_ACTIVE   = 3'b100
    } t_sup_state;

    // reported state codes
    localparam logic [1:0] CODE_DISABLED = 2'd0;
    localparam logic [1:0] CODE_ENABLED  = 2'd1;
    localparam logic [1:0] CODE_ACTIVE   = 2'd2;

    // drive select codes
    localparam logic [1:0] DRV_OFF = 2'd0;
    localparam logic [1:0] DRV_3V3 = 2'd1;
    localparam logic [1:0] DRV_5V  = 2'd2;

    localparam logic [7:0] REQ_3V3 = 8'd1;
    localparam logic [7:0] REQ_5V  = 8'd2;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SETTLE_TICKS   = 3'd0,
        REG_REENABLE_BELOW = 3'd1,
        REG_FOREIGN_ABOVE  = 3'd2,
        REG_USB_ON_BELOW   = 3'd3,
        REG_USB_OFF_ABOVE  = 3'd4,
        REG_FIVE_VOLT_MIN  = 3'd5,
        REG_THREE_VOLT_MIN = 3'd6,
        REG_THREE_VOLT_MAX = 3'd7
    } t_reg_idx;

    localparam logic        [15:0] RST_SETTLE_TICKS   = 16'd25000;
    localparam logic signed [11:0] RST_REENABLE_BELOW = 12'sd111;
    localparam logic signed [11:0] RST_FOREIGN_ABOVE  = 12'sd185;
    localparam logic signed [11:0] RST_USB_ON_BELOW   = 12'sd1332;
    localparam logic signed [11:0] RST_USB_OFF_ABOVE  = 12'sd1480;
    localparam logic signed [11:0] RST_FIVE_VOLT_MIN  = 12'sd1630;
    localparam logic signed [11:0] RST_THREE_VOLT_MIN = 12'sd1110;
    localparam logic signed [11:0] RST_THREE_VOLT_MAX = 12'sd1332;

    function automatic logic [1:0] state_code(input t_sup_state st);
        logic [1:0] code;
        unique case (st)
            ST_DISABLED: code = CODE_DISABLED;
            ST_ENABLED:  code = CODE_ENABLED;
            ST_ACTIVE:   code = CODE_ACTIVE;
            default:     code = CODE_DISABLED;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/io_supply_drive_supervisor_core.sv -----
// i/o supply drive supervisor: sample hysteresis, drive state and settle timer
// depends on iosds_pkg and io_supply_drive_supervisor_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// Supervises a target supply driven at 3.3 V or 5 V. Each input beat (tick,
// target sample, usb sample or drive request, selected by tuser) yields exactly
// one result beat carrying the drive state, drive code, power switch level and
// the two report flags. One beat is accepted every clock cycle unless the result
// side stalls; a result leaves through the input register, then the result
// register, and the only loop is the state update between those two registers.
// Backpressure on the result side stalls both registers together. Configuration
// writes are always accepted and should only be made while no beat is in flight.

`include "io_supply_drive_supervisor_core_macros.svh"

module io_supply_drive_supervisor_core
    import iosds_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input beats
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // sample[11:0], drive_request[19:12], zero
    input  wire logic [1:0]  i_s_axis_tuser,  // cmd[1:0]
    // result beats
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,  // drive_state[1:0], drive_code[3:2],
                                              // usb_power_switch[4], list_report_due[5],
                                              // state_report_due[6], zero[7]
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    // configuration
    logic        [15:0] r_settle_ticks;
    logic signed [11:0] r_reenable_below;
    logic signed [11:0] r_foreign_above;
    logic signed [11:0] r_usb_on_below;
    logic signed [11:0] r_usb_off_above;
    logic signed [11:0] r_five_volt_min;
    logic signed [11:0] r_three_volt_min;
    logic signed [11:0] r_three_volt_max;

    // input register
    logic               r_in_valid;
    t_cmd               r_in_cmd;
    logic signed [11:0] r_in_sample;
    logic        [7:0]  r_in_req;

    // supervisor state
    logic signed [11:0]     r_target;
    t_sup_state             r_state;
    logic [1:0]             r_sel;
    logic                   r_switch;
    logic [TIMER_BITS-1:0]  r_count;
    logic                   r_running;

    // next state
    logic signed [11:0]     n_target;
    t_sup_state             n_state;
    logic [1:0]             n_sel;
    logic                   n_switch;
    logic [TIMER_BITS-1:0]  n_count;
    logic                   n_running;
    logic                   n_list_due;
    logic                   n_state_due;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_data;

    logic advance;
    logic expired;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks   <= RST_SETTLE_TICKS;
            r_reenable_below <= RST_REENABLE_BELOW;
            r_foreign_above  <= RST_FOREIGN_ABOVE;
            r_usb_on_below   <= RST_USB_ON_BELOW;
            r_usb_off_above  <= RST_USB_OFF_ABOVE;
            r_five_volt_min  <= RST_FIVE_VOLT_MIN;
            r_three_volt_min <= RST_THREE_VOLT_MIN;
            r_three_volt_max <= RST_THREE_VOLT_MAX;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SETTLE_TICKS:   r_settle_ticks   <= i_cfg_data;
                REG_REENABLE_BELOW: r_reenable_below <= i_cfg_data[11:0];
                REG_FOREIGN_ABOVE:  r_foreign_above  <= i_cfg_data[11:0];
                REG_USB_ON_BELOW:   r_usb_on_below   <= i_cfg_data[11:0];
                REG_USB_OFF_ABOVE:  r_usb_off_above  <= i_cfg_data[11:0];
                REG_FIVE_VOLT_MIN:  r_five_volt_min  <= i_cfg_data[11:0];
                REG_THREE_VOLT_MIN: r_three_volt_min <= i_cfg_data[11:0];
                REG_THREE_VOLT_MAX: r_three_volt_max <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd    <= t_cmd'(i_s_axis_tuser);
            r_in_sample <= i_s_axis_tdata[11:0];
            r_in_req    <= i_s_axis_tdata[19:12];
        end
    end

    // one pass over the item, in the order: command, re-enable, disable, window
    always_comb begin
        n_target    = r_target;
        n_state     = r_state;
        n_sel       = r_sel;
        n_switch    = r_switch;
        n_count     = r_count;
        n_running   = r_running;
        n_list_due  = 1'b0;
        n_state_due = 1'b0;
        expired     = 1'b0;

        unique case (r_in_cmd)
            CMD_TICK: begin
                if (r_running && (r_count != '1)) begin
                    n_count = r_count + TIMER_BITS'(1);
                end
            end
            CMD_TARGET: begin
                n_target = r_in_sample;
            end
            CMD_USB: begin
                if (r_in_sample < r_usb_on_below) begin
                    n_switch = 1'b1;
                end
                if (r_in_sample > r_usb_off_above) begin
                    n_switch = 1'b0;
                end
            end
            CMD_DRIVE: begin
                n_sel   = DRV_OFF;
                n_count = '0;
                if (((r_in_req == REQ_3V3) || (r_in_req == REQ_5V))
                        && (r_state != ST_DISABLED)) begin
                    n_running = 1'b1;
                    n_state   = ST_ACTIVE;
                    n_sel     = r_in_req[1:0];
                end else begin
                    n_running = 1'b0;
                    if (r_state == ST_DISABLED) begin
                        n_list_due = 1'b1;
                    end
                    n_state = ST_ENABLED;
                end
                n_state_due = 1'b1;
            end
            default: ;
        endcase

        if ((n_state == ST_DISABLED) && (n_target < r_reenable_below) && !n_switch) begin
            n_state    = ST_ENABLED;
            n_list_due = 1'b1;
        end

        if (((n_state == ST_ENABLED) && (n_target > r_foreign_above))
                || ((n_state != ST_DISABLED) && n_switch)) begin
            n_sel      = DRV_OFF;
            n_count    = '0;
            n_running  = 1'b0;
            n_state    = ST_DISABLED;
            n_list_due = 1'b1;
        end

        expired = (n_state == ST_ACTIVE) && n_running
                  && (CMP_W'(n_count) >= CMP_W'(r_settle_ticks));

        // out of window: drop as an off request from the active state
        if (expired && (((n_sel == DRV_5V) && (n_target < r_five_volt_min))
                || ((n_sel == DRV_3V3) && ((n_target < r_three_volt_min)
                    || (n_target > r_three_volt_max))))) begin
            n_sel       = DRV_OFF;
            n_count     = '0;
            n_running   = 1'b0;
            n_state     = ST_ENABLED;
            n_state_due = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_state   <= ST_ENABLED;
            r_sel     <= DRV_OFF;
            r_switch  <= 1'b1;
            r_count   <= '0;
            r_running <= 1'b0;
        end else if (r_in_valid && advance) begin
            r_target  <= n_target;
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_switch  <= n_switch;
            r_count   <= n_count;
            r_running <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out_data <= {1'b0, n_state_due, n_list_due, n_switch, n_sel,
                           state_code(n_state)};
        end
    end

    `IOSDS_ASSERT(a_sel_only_active, (r_sel == DRV_OFF) || (r_state == ST_ACTIVE), "drive code set outside active state")
    `IOSDS_ASSERT(a_timer_only_active, !r_running || (r_state == ST_ACTIVE), "settle timer running outside active state")
    `IOSDS_ASSERT_NEXT(a_item_to_result, r_in_valid && advance, r_out_valid, "held item produced no result beat")
    `IOSDS_ASSERT_NEXT(a_stall_holds_item, r_in_valid && !advance, r_in_valid, "stalled item lost from input register")

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// testbench for io_supply_drive_supervisor_core: directed table, then random phases
// depends on iosds_pkg; results are checked against known rows or an in-bench model of the supervisor
`timescale 1ns / 1ps

module tb_top;
    import iosds_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES    = 4;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 140;
    localparam int MAX_PRINTED    = 100;
    localparam logic [7:0] REQ_OFF = 8'd0;

    // result fields, msb first, so the packed value lines up with tdata[6:0]
    typedef struct packed {
        logic       state_due;
        logic       list_due;
        logic       power;
        logic [1:0] code;
        logic [1:0] state;
    } t_status;

    typedef struct {
        t_cmd        cmd;
        logic [11:0] smp;
        logic [7:0]  req;
        bit          known;
        logic [6:0]  exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata  = '0;
    logic [1:0]  i_s_axis_tuser  = CMD_TICK;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index     = REG_SETTLE_TICKS;
    logic [15:0] i_cfg_data      = '0;

    io_supply_drive_supervisor_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // supervisor model: limits
    logic        [15:0] th_settle   = RST_SETTLE_TICKS;
    logic signed [11:0] th_reenable = RST_REENABLE_BELOW;
    logic signed [11:0] th_foreign  = RST_FOREIGN_ABOVE;
    logic signed [11:0] th_usb_on   = RST_USB_ON_BELOW;
    logic signed [11:0] th_usb_off  = RST_USB_OFF_ABOVE;
    logic signed [11:0] th_5v_min   = RST_FIVE_VOLT_MIN;
    logic signed [11:0] th_3v_min   = RST_THREE_VOLT_MIN;
    logic signed [11:0] th_3v_max   = RST_THREE_VOLT_MAX;

    // supervisor model: state
    logic signed [11:0] lvl_target = '0;
    logic signed [11:0] lvl_usb    = '0;
    logic        [1:0]  sup_code   = CODE_ENABLED;
    logic        [1:0]  drv_sel    = DRV_OFF;
    logic               pwr_on     = 1'b1;
    logic        [15:0] settle_cnt = '0;
    logic               settle_run = 1'b0;

    logic signed [11:0] reset_limits [7] = '{RST_REENABLE_BELOW, RST_FOREIGN_ABOVE,
        RST_USB_ON_BELOW, RST_USB_OFF_ABOVE, RST_FIVE_VOLT_MIN, RST_THREE_VOLT_MIN,
        RST_THREE_VOLT_MAX};

    t_status expected_status_q [$];
    int      mismatches     = 0;
    int      results_seen   = 0;
    int      tx_idle_pct    = 0;
    int      rx_stall_pct   = 0;
    int      hold_serial    = 0;
    int      stalled_cycles = 0;

    // exp is {state_due, list_due, power, code, state}
    localparam int N_ROWS     = 27;
    localparam int WINDOW_ROW = 8;
    t_row directed_rows [N_ROWS] = '{
        '{CMD_TICK,   12'h000, REQ_OFF, 1'b1, 7'h30},  // power on from reset disables
        '{CMD_USB,    12'h7FF, REQ_OFF, 1'b1, 7'h21},  // switch off, target low: enabled
        '{CMD_DRIVE,  12'h000, REQ_5V,  1'b1, 7'h4A},
        '{CMD_TARGET, 12'h7FF, REQ_OFF, 1'b0, 7'h00},
        '{CMD_DRIVE,  12'h000, 8'hFF,   1'b1, 7'h60},  // off, then foreign voltage
        '{CMD_TARGET, 12'h800, REQ_OFF, 1'b1, 7'h21},
        '{CMD_DRIVE,  12'h000, REQ_OFF, 1'b0, 7'h00},
        '{CMD_DRIVE,  12'h000, REQ_3V3, 1'b1, 7'h46},
        // settle time shortened to two ticks from here on
        '{CMD_TICK,   12'h000, REQ_OFF, 1'b0, 7'h00},
        '{CMD_TARGET, 12'd1200, REQ_OFF, 1'b0, 7'h00},
        '{CMD_TICK,   12'h000, REQ_OFF, 1'b0, 7'h00},
        '{CMD_TARGET, 12'd1333, REQ_OFF, 1'b0, 7'h00}, // just above the 3.3 v window
        '{CMD_TICK,   12'h000, REQ_OFF, 1'b1, 7'h20},
        '{CMD_TARGET, 12'h000, REQ_OFF, 1'b1, 7'h21},
        '{CMD_DRIVE,  12'h000, REQ_5V,  1'b1, 7'h4A},
        '{CMD_TARGET, 12'd1629, REQ_OFF, 1'b0, 7'h00}, // just below the 5 v minimum
        '{CMD_TICK,   12'h000, REQ_OFF, 1'b0, 7'h00},
        '{CMD_TICK,   12'h000, REQ_OFF, 1'b0, 7'h00},
        '{CMD_USB,    12'd1331, REQ_OFF, 1'b1, 7'h30},
        '{CMD_DRIVE,  12'h000, REQ_3V3, 1'b1, 7'h70},  // request while disabled
        '{CMD_USB,    12'd1480, REQ_OFF, 1'b1, 7'h10}, // inside the hysteresis band
        '{CMD_USB,    12'd1481, REQ_OFF, 1'b1, 7'h00}, // switch off, target still high
        '{CMD_DRIVE,  12'h000, 8'd3,    1'b0, 7'h00},
        '{CMD_DRIVE,  12'h000, REQ_5V,  1'b0, 7'h00},
        '{CMD_TARGET, 12'd1630, REQ_OFF, 1'b0, 7'h00},
        '{CMD_TICK,   12'h000, REQ_OFF, 1'b0, 7'h00},
        '{CMD_TICK,   12'h000, REQ_OFF, 1'b0, 7'h00}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void apply_drive_request(logic [7:0] req, inout logic list_due,
                                                inout logic state_due);
        drv_sel    = DRV_OFF;
        settle_cnt = '0;
        if ((req == REQ_3V3 || req == REQ_5V) && sup_code != CODE_DISABLED) begin
            settle_run = 1'b1;
            sup_code   = CODE_ACTIVE;
            drv_sel    = req[1:0];
        end else begin
            settle_run = 1'b0;
            if (sup_code == CODE_DISABLED)
                list_due = 1'b1;
            sup_code = CODE_ENABLED;
        end
        state_due = 1'b1;
    endfunction

    function automatic t_status next_supervisor_status(t_cmd c, logic signed [11:0] smp,
                                                       logic [7:0] req);
        logic    list_due;
        logic    state_due;
        t_status st;
        list_due  = 1'b0;
        state_due = 1'b0;
        case (c)
            CMD_TICK: begin
                if (settle_run && settle_cnt != 16'hFFFF)
                    settle_cnt = settle_cnt + 16'd1;
            end
            CMD_TARGET: lvl_target = smp;
            CMD_USB: begin
                lvl_usb = smp;
                if (lvl_usb < th_usb_on)
                    pwr_on = 1'b1;
                // off test second: it wins when both hold
                if (lvl_usb > th_usb_off)
                    pwr_on = 1'b0;
            end
            CMD_DRIVE: apply_drive_request(req, list_due, state_due);
            default: ;
        endcase
        if (sup_code == CODE_DISABLED && lvl_target < th_reenable && !pwr_on) begin
            sup_code = CODE_ENABLED;
            list_due = 1'b1;
        end
        if ((sup_code == CODE_ENABLED && lvl_target > th_foreign) ||
            (sup_code != CODE_DISABLED && pwr_on)) begin
            drv_sel    = DRV_OFF;
            settle_cnt = '0;
            settle_run = 1'b0;
            sup_code   = CODE_DISABLED;
            list_due   = 1'b1;
        end
        if (sup_code == CODE_ACTIVE && settle_run && settle_cnt >= th_settle) begin
            if ((drv_sel == DRV_5V && lvl_target < th_5v_min) ||
                (drv_sel == DRV_3V3 && (lvl_target < th_3v_min || lvl_target > th_3v_max)))
                apply_drive_request(REQ_OFF, list_due, state_due);
        end
        st.state_due = state_due;
        st.list_due  = list_due;
        st.power     = pwr_on;
        st.code      = drv_sel;
        st.state     = sup_code;
        return st;
    endfunction

    function automatic logic signed [11:0] near(logic signed [11:0] th, int lo, int hi);
        int v;
        v = int'(th) + lo + int'($urandom_range(hi - lo, 0));
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return 12'(v);
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        if (mismatches < MAX_PRINTED)
            $display("mismatch in %s of result %0d: got %0d, expected %0d",
                     field, results_seen, got, want);
        mismatches++;
    endtask

    task automatic send_item(t_cmd c, logic [11:0] smp, logic [7:0] req,
                             bit known = 1'b0, t_status typed = '0);
        t_status predicted;
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= c;
        i_s_axis_tdata  <= {4'b0, req, smp};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = next_supervisor_status(c, smp, req);
        expected_status_q.push_back(known ? typed : predicted);
    endtask

    task automatic wait_results_done();
        i_s_axis_tvalid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SETTLE_TICKS:   th_settle   = val;
            REG_REENABLE_BELOW: th_reenable = val[11:0];
            REG_FOREIGN_ABOVE:  th_foreign  = val[11:0];
            REG_USB_ON_BELOW:   th_usb_on   = val[11:0];
            REG_USB_OFF_ABOVE:  th_usb_off  = val[11:0];
            REG_FIVE_VOLT_MIN:  th_5v_min   = val[11:0];
            REG_THREE_VOLT_MIN: th_3v_min   = val[11:0];
            REG_THREE_VOLT_MAX: th_3v_max   = val[11:0];
            default: ;
        endcase
    endtask

    // result side: random stalls, plus one long hold-off per hold_serial bump
    initial begin : result_sink
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_serial != hold_seen) begin
                hold_seen = hold_serial;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        logic [7:0] got;
        t_status    want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            results_seen++;
            if (expected_status_q.size() == 0) begin
                report_mismatch("beat with nothing expected", int'(got), 0);
            end else begin
                want = expected_status_q.pop_front();
                if (got[1:0] !== want.state)
                    report_mismatch("drive_state", int'(got[1:0]), int'(want.state));
                if (got[3:2] !== want.code)
                    report_mismatch("drive_code", int'(got[3:2]), int'(want.code));
                if (got[4] !== want.power)
                    report_mismatch("usb_power_switch", int'(got[4]), int'(want.power));
                if (got[5] !== want.list_due)
                    report_mismatch("list_report_due", int'(got[5]), int'(want.list_due));
                if (got[6] !== want.state_due)
                    report_mismatch("state_report_due", int'(got[6]), int'(want.state_due));
                if (got[7] !== 1'b0)
                    report_mismatch("padding bit", int'(got[7]), 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial begin : watchdog
        while (stalled_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] v [8];
        int          n;
        int          len;
        bit          paused;
        logic [7:0]  req;
        logic [11:0] lvl;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (i == WINDOW_ROW) begin
                wait_results_done();
                write_reg(REG_SETTLE_TICKS, 16'd2);
                i_cfg_valid <= 1'b0;
            end
            send_item(directed_rows[i].cmd, directed_rows[i].smp, directed_rows[i].req,
                      directed_rows[i].known, t_status'(directed_rows[i].exp));
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin
                    v[0] = 16'd3;
                    for (int i = 1; i < 8; i++)
                        v[i] = 16'(reset_limits[i - 1]);
                end
                // limits pinned at the ends of their ranges
                1: v = '{16'd1, 16'h07FF, 16'h07FF, 16'hF800, 16'hF800,
                         16'h07FF, 16'hF800, 16'h07FF};
                2: v = '{16'hFFFF, 16'hF800, 16'hF800, 16'h07FF, 16'hF800,
                         16'hF800, 16'h07FF, 16'hF800};
                N_PHASES - 1: begin
                    for (int i = 0; i < 8; i++)
                        v[i] = 16'($urandom);
                end
                default: begin
                    v[0] = 16'($urandom_range(6, 1));
                    for (int i = 1; i < 8; i++)
                        v[i] = {4'($urandom), near(reset_limits[i - 1], -150, 150)};
                end
            endcase
            wait_results_done();
            for (int i = 0; i < 8; i++)
                write_reg(t_reg_idx'(i), v[i]);
            i_cfg_valid <= 1'b0;

            tx_idle_pct  = (p % 4 == 1) ? 45 : (p % 4 == 3) ? 20 : 0;
            rx_stall_pct = (p % 4 == 2) ? 45 : (p % 4 == 3) ? 20 : 0;
            if (p == 3)
                hold_serial++;
            paused = 1'b0;
            n      = 0;

            while (n < PHASE_ITEMS) begin
                if (p == 4 && !paused && n >= PHASE_ITEMS / 2) begin
                    wait_results_done();
                    paused = 1'b1;
                end
                if ($urandom_range(99, 0) < 75) begin
                    // switch off, target quiet, start a drive, then let it settle
                    send_item(CMD_USB, near(th_usb_off, 1, 40), REQ_OFF);
                    send_item(CMD_TARGET, near(th_reenable, -40, -1), REQ_OFF);
                    case ($urandom_range(9, 0))
                        0:       req = 8'($urandom);
                        1, 2, 3, 4: req = REQ_3V3;
                        default: req = REQ_5V;
                    endcase
                    send_item(CMD_DRIVE, 12'($urandom), req);
                    n += 3;
                    len = $urandom_range(14, 2);
                    for (int k = 0; k < len; k++) begin
                        case ($urandom_range(5, 0))
                            0:       lvl = near(th_3v_min, -3, 3);
                            1:       lvl = near(th_3v_max, -3, 3);
                            2:       lvl = near(th_5v_min, -3, 3);
                            3:       lvl = near(th_foreign, -3, 3);
                            4:       lvl = near(th_reenable, -3, 3);
                            default: lvl = 12'($urandom);
                        endcase
                        case ($urandom_range(19, 0)) inside
                            [0:10]:  send_item(CMD_TICK, 12'($urandom), 8'($urandom));
                            [11:17]: send_item(CMD_TARGET, lvl, REQ_OFF);
                            18:      send_item(CMD_USB, near(th_usb_on, -3, 3), REQ_OFF);
                            default: send_item(CMD_USB, near(th_usb_off, -3, 3), REQ_OFF);
                        endcase
                        n++;
                    end
                end else begin
                    len = $urandom_range(6, 1);
                    for (int k = 0; k < len; k++)
                        send_item(t_cmd'($urandom_range(3, 0)), 12'($urandom), 8'($urandom));
                    n += len;
                end
            end
        end

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_status_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- io_supply_drive_supervisor_core.f -----
+incdir+rtl
rtl/iosds_pkg.sv
rtl/io_supply_drive_supervisor_core.sv
tb/sv/tb_top.sv
